FILE: hdl/utdec_pkg.sv
// Package for the UTF-8 to code point decoder.
// Holds the shared constants, the inter-stage structs and the lead byte helpers.
// Used by every module of the decoder; depends on nothing.
package utdec_pkg;

    localparam int unsigned MAX_SEQUENCE_BYTES = 7;
    localparam int unsigned BYTE_W             = 8;
    localparam int unsigned CP_W               = 36;
    localparam int unsigned COUNT_W            = 3;
    localparam int unsigned ONES_W             = 4;
    localparam int unsigned CONT_BITS          = 6;

    // Width of the payload kept from a lead byte at the shortest sequence.
    localparam int unsigned LEAD_W             = 5;

    // Byte count of a single-byte character.
    localparam logic [COUNT_W-1:0] SINGLE_BYTE_COUNT = COUNT_W'(1);

    // Item held in the input register.
    typedef struct packed {
        logic                  valid;
        logic [BYTE_W-1:0]     text_byte;
        logic                  end_of_text;
    } in_item_t;

    // Result handed from the decode logic to the output register.
    typedef struct packed {
        logic                  load;
        logic [CP_W-1:0]       code_point;
        logic [COUNT_W-1:0]    byte_count;
    } result_t;

    // Number of leading one bits of a byte, 0 to 8.
    function automatic logic [ONES_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [ONES_W-1:0] n;
        begin
            casez (b)
                8'b0???????: n = ONES_W'(0);
                8'b10??????: n = ONES_W'(1);
                8'b110?????: n = ONES_W'(2);
                8'b1110????: n = ONES_W'(3);
                8'b11110???: n = ONES_W'(4);
                8'b111110??: n = ONES_W'(5);
                8'b1111110?: n = ONES_W'(6);
                8'b11111110: n = ONES_W'(7);
                8'b11111111: n = ONES_W'(8);
                default:     n = ONES_W'(0);
            endcase
            return n;
        end
    endfunction

    // Payload bits of a lead byte with t leading ones: its low 7-t bits.
    function automatic logic [LEAD_W-1:0] lead_bits(
        input logic [BYTE_W-1:0] b,
        input logic [ONES_W-1:0] t
    );
        logic [LEAD_W-1:0] v;
        begin
            case (t)
                ONES_W'(2): v = b[4:0];
                ONES_W'(3): v = {1'b0, b[3:0]};
                ONES_W'(4): v = {2'b0, b[2:0]};
                ONES_W'(5): v = {3'b0, b[1:0]};
                ONES_W'(6): v = {4'b0, b[0]};
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: hdl/utdec_in_stage.sv
// Input register of the UTF-8 decoder.
// Captures one item per cycle while s_ready is high; depends on utdec_pkg.
module utdec_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [utdec_pkg::BYTE_W-1:0]      s_text_byte,
    input  logic                              s_end_of_text,
    input  logic                              consume,
    output utdec_pkg::in_item_t               in_item
);
    import utdec_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              eot_reg;

    // The register takes a new item when empty or when its item moves on.
    assign s_ready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (consume) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
            eot_reg  <= s_end_of_text;
        end
    end

    assign in_item.valid       = valid_reg;
    assign in_item.text_byte   = byte_reg;
    assign in_item.end_of_text = eot_reg;

endmodule

FILE: hdl/utdec_core.sv
// Decode logic and sequence state of the UTF-8 decoder.
// Folds one byte per cycle into the partial code point while advance is high; depends on utdec_pkg.
module utdec_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utdec_pkg::in_item_t   in_item,
    input  logic                  advance,
    output utdec_pkg::result_t    result
);
    import utdec_pkg::*;

    logic [CP_W-1:0]    partial_reg;
    logic [CP_W-1:0]    partial_next;
    logic [COUNT_W-1:0] owed_reg;
    logic [COUNT_W-1:0] owed_next;
    logic [COUNT_W-1:0] length_reg;
    logic [COUNT_W-1:0] length_next;

    logic [ONES_W-1:0]  ones;
    logic [CP_W-1:0]    shifted;

    assign ones    = lead_ones(in_item.text_byte);
    assign shifted = {partial_reg[CP_W-CONT_BITS-1:0], in_item.text_byte[CONT_BITS-1:0]};

    // Next state and result for the byte in the input register.
    always_comb begin
        partial_next      = partial_reg;
        owed_next         = owed_reg;
        length_next       = length_reg;
        result.load       = 1'b0;
        result.code_point = shifted;
        result.byte_count = length_reg;

        if (owed_reg != '0) begin
            // Inside a sequence every byte is taken as a continuation byte.
            partial_next = shifted;
            owed_next    = owed_reg - COUNT_W'(1);
            if (owed_reg == COUNT_W'(1)) begin
                result.load  = advance;
                partial_next = '0;
                length_next  = '0;
            end
        end else if (ones == '0) begin
            // A plain ASCII byte is a character of its own.
            result.load       = advance;
            result.code_point = CP_W'(in_item.text_byte);
            result.byte_count = SINGLE_BYTE_COUNT;
        end else if (ones >= ONES_W'(2) && ones <= ONES_W'(MAX_SEQUENCE_BYTES)) begin
            // A lead byte opens a sequence.
            partial_next = CP_W'(lead_bits(in_item.text_byte, ones));
            owed_next    = ones[COUNT_W-1:0] - COUNT_W'(1);
            length_next  = ones[COUNT_W-1:0];
        end
        // A stray continuation byte or an invalid lead is skipped.

        if (in_item.end_of_text) begin
            partial_next = '0;
            owed_next    = '0;
            length_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            owed_reg    <= '0;
            length_reg  <= '0;
        end else if (advance) begin
            partial_reg <= partial_next;
            owed_reg    <= owed_next;
            length_reg  <= length_next;
        end
    end

endmodule

FILE: hdl/utdec_out_stage.sv
// Output register of the UTF-8 decoder.
// Holds one result until the result channel takes it; depends on utdec_pkg.
module utdec_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  utdec_pkg::result_t                result,
    output logic                              out_free,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utdec_pkg::CP_W-1:0]        m_code_point,
    output logic [utdec_pkg::COUNT_W-1:0]     m_byte_count
);
    import utdec_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [CP_W-1:0]    cp_reg;
    logic [COUNT_W-1:0] count_reg;

    // Free when empty or when the held item leaves this cycle.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (result.load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            cp_reg    <= result.code_point;
            count_reg <= result.byte_count;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = cp_reg;
    assign m_byte_count = count_reg;

endmodule

FILE: hdl/utf8_to_code_point_decoder_unit.sv
// Top level of the UTF-8 to code point decoder.
// Instantiates utdec_in_stage, utdec_core and utdec_out_stage; uses utdec_pkg.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_text_byte[7:0], s_end_of_text
//   m_       out        m_valid/m_ready    m_code_point[35:0], m_byte_count[2:0]
//
// One byte is taken per cycle while the output side is free; the byte that completes a result
// is registered in the input register, decoded out of it and registered in the output register.
// The decode between the two registers is a leading-ones search and a
// six-bit shift of the partial value, so throughput is one byte per cycle while m_ready is high.
// Synchronous active-low reset empties both registers and closes any sequence.
// While a result waits on m_ready the input byte waits too, so s_ready drops when both are full.
module utf8_to_code_point_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [utdec_pkg::BYTE_W-1:0]      s_text_byte,
    input  logic                              s_end_of_text,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utdec_pkg::CP_W-1:0]        m_code_point,
    output logic [utdec_pkg::COUNT_W-1:0]     m_byte_count
);
    import utdec_pkg::*;

    in_item_t in_item;
    result_t  result;
    logic     out_free;
    logic     advance;

    // A byte moves through the decode when the output side can take a result.
    assign advance = in_item.valid && out_free;

    utdec_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .consume       (advance),
        .in_item       (in_item)
    );

    utdec_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (in_item),
        .advance (advance),
        .result  (result)
    );

    utdec_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .result       (result),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_byte_count (m_byte_count)
    );

`ifndef SYNTHESIS
    // A held result that is not taken is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !result.load)
        else $error("output register overwritten while stalled");

    // Every result reports a sequence of at least one byte.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        result.load |-> (result.byte_count != '0))
        else $error("result with zero byte count");

    // A single-byte result is an ASCII value.
    a_ascii_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.load && result.byte_count == SINGLE_BYTE_COUNT)
            |-> (result.code_point[CP_W-1:BYTE_W-1] == '0))
        else $error("single-byte result out of ASCII range");

    // A result is only produced from a byte held in the input register.
    a_load_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        result.load |-> in_item.valid)
        else $error("result produced without an input item");
`endif

endmodule
